// ===== rtl/iorjw_pkg.sv =====
// Shared types and constants for the in-order retire job window.
package iorjw_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int VAL_W  = 32;

  typedef enum logic [1:0] {
    OP_ADD         = 2'd0,
    OP_COMPLETE    = 2'd1,
    OP_READ_OLDEST = 2'd2,
    OP_TAKE        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_READY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_RDWAIT,
    S_OUT
  } state_t;

endpackage

// ===== rtl/iorjw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module iorjw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/in_order_retire_job_window.sv =====
// Top level of the in-order retire job window: sequencer, flags and value RAM.
//
//  channel   dir  ports                       beat contents (low bit first)
//  --------  ---  --------------------------  ------------------------------------------
//  in        in   in_tvalid/tready/tdata/tuser tdata: job_value[31:0], position[35:32];
//                                              tuser: operation[1:0]
//  out       out  out_tvalid/tready/tdata/tuser tdata: data[31:0], slot_written[35:32],
//                                              occupied[40:36]; tuser: status[1:0]
//  cfg       in   cfg_wr_en/cfg_wr_data       queue_size[4:0], no handshake back
//
//  A beat goes through accept, execute and present for add and for a refused
//  take; read-oldest and a good take add a wait state for the registered RAM
//  read, and complete adds a retire walk over N (0..16) done entries: the
//  walk advances the head one slot per cycle through the shared index
//  incrementer and leaves once the window is empty or the head slot is not
//  done. in_tready is low while a beat is at
//  work or its result waits on out_tready. Reset (rst_n low, synchronous)
//  clears the indices, the count, and the per-slot valid, ready and nonzero
//  flags at once; a slot whose valid flag is clear reads as zero.
module in_order_retire_job_window
  import iorjw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: job_value[31:0], position[35:32], zero pad [39:36]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // in_tuser: operation[1:0]
  input  logic [1:0]  in_tuser,
  // out_tdata: data[31:0], slot_written[35:32], occupied[40:36], zero pad [47:41]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  qsize_r;
  logic [DEPTH-1:0]  valid_r, valid_nxt;
  logic [DEPTH-1:0]  rdy_r, rdy_nxt;
  logic [DEPTH-1:0]  nz_r, nz_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  status_t           status_r, status_nxt;
  logic [VAL_W-1:0]  data_r, data_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;

  logic [CNT_W-1:0]  eff_size;
  logic [IDX_W-1:0]  idx_in;
  logic [CNT_W-1:0]  idx_inc;
  logic [IDX_W-1:0]  idx_next;
  logic              walk_step;

  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  // Clamp the programmed size into 1..DEPTH.
  always_comb begin
    eff_size = qsize_r;
    if (qsize_r == '0) begin
      eff_size = CNT_W'(1);
    end else if (qsize_r > CNT_W'(DEPTH)) begin
      eff_size = CNT_W'(DEPTH);
    end
  end

  // Shared index unit: advance the head while walking, the tail otherwise.
  assign idx_in   = (state_r == S_WALK) ? head_r : tail_r;
  assign idx_inc  = {1'b0, idx_in} + CNT_W'(1);
  assign idx_next = (idx_inc >= eff_size || idx_inc >= CNT_W'(DEPTH)) ? '0
                                                                      : idx_inc[IDX_W-1:0];

  // Retire the head while entries are held and the head slot is done.
  assign walk_step = (count_r != '0) && !nz_r[head_r];

  iorjw_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_COMPLETE:    state_nxt = S_WALK;
          OP_READ_OLDEST: state_nxt = S_RDWAIT;
          OP_TAKE:        state_nxt = rdy_r[pos_r] ? S_RDWAIT : S_OUT;
          default:        state_nxt = S_OUT;
        endcase
      end
      S_WALK: begin
        if (!walk_step) begin
          state_nxt = S_OUT;
        end
      end
      S_RDWAIT: state_nxt = S_OUT;
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and flag updates.
  always_comb begin
    op_nxt     = op_r;
    val_nxt    = val_r;
    pos_nxt    = pos_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    valid_nxt  = valid_r;
    rdy_nxt    = rdy_r;
    nz_nxt     = nz_r;
    rd_idx_nxt = rd_idx_r;
    status_nxt = status_r;
    data_nxt   = data_r;
    slot_nxt   = slot_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = pos_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = op_t'(in_tuser);
          val_nxt    = in_tdata[VAL_W-1:0];
          pos_nxt    = in_tdata[VAL_W+IDX_W-1:VAL_W];
          status_nxt = ST_OK;
          data_nxt   = '0;
          slot_nxt   = '0;
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_ADD: begin
            if (count_r >= eff_size) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we            = 1'b1;
              valid_nxt[tail_r] = 1'b1;
              rdy_nxt[tail_r]   = 1'b1;
              nz_nxt[tail_r]    = |val_r;
              slot_nxt          = tail_r;
              tail_nxt          = idx_next;
              count_nxt         = count_r + CNT_W'(1);
            end
          end
          OP_COMPLETE: begin
            // A cleared valid bit reads as zero: no RAM write needed.
            valid_nxt[pos_r] = 1'b0;
            nz_nxt[pos_r]    = 1'b0;
          end
          OP_READ_OLDEST: begin
            ram_re     = 1'b1;
            ram_raddr  = head_r;
            rd_idx_nxt = head_r;
          end
          OP_TAKE: begin
            if (rdy_r[pos_r]) begin
              rdy_nxt[pos_r] = 1'b0;
              ram_re         = 1'b1;
              rd_idx_nxt     = pos_r;
            end else begin
              status_nxt = ST_NOT_READY;
            end
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
      end
      S_WALK: begin
        if (walk_step) begin
          head_nxt  = idx_next;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      S_RDWAIT: begin
        data_nxt = valid_r[rd_idx_r] ? ram_rdata : '0;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      qsize_r <= CNT_W'(DEPTH);
      valid_r <= '0;
      rdy_r   <= '0;
      nz_r    <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      rdy_r   <= rdy_nxt;
      nz_r    <= nz_nxt;
      if (cfg_wr_en) begin
        qsize_r <= cfg_wr_data;
      end
    end
  end

  // Payload holds need no reset.
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    pos_r    <= pos_nxt;
    rd_idx_r <= rd_idx_nxt;
    status_r <= status_nxt;
    data_r   <= data_nxt;
    slot_r   <= slot_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {7'd0, count_r, slot_r, data_r};
  assign out_tuser  = status_r;

endmodule

// ===== test/iorjw_window_checker.sv =====
`timescale 1ns / 1ps
// Monitor for the job window: models every accepted beat and checks each result beat.
module iorjw_window_checker
  import iorjw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  output int          fail_count,
  output int          reply_backlog
);

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] data;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] occupied;
  } job_reply_t;

  logic [4:0]       size_reg;
  logic [VAL_W-1:0] slot_val [DEPTH];
  logic             slot_rdy [DEPTH];
  logic [IDX_W-1:0] head_ptr;
  logic [IDX_W-1:0] tail_ptr;
  logic [CNT_W-1:0] held;
  job_reply_t       reply_q [$];
  int               n_bad;

  // Slots in use: the programmed size clamped to 1..DEPTH.
  function automatic int window_span();
    if (size_reg == 0) return 1;
    if (size_reg > DEPTH) return DEPTH;
    return size_reg;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_next(logic [IDX_W-1:0] idx);
    int nxt;
    nxt = idx + 1;
    if (nxt >= window_span()) nxt = 0;
    return nxt[IDX_W-1:0];
  endfunction

  function automatic job_reply_t job_window_step(op_t op, logic [VAL_W-1:0] val,
                                                 logic [IDX_W-1:0] pos);
    job_reply_t r;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ADD: begin
        if (held >= window_span()) begin
          r.status = ST_FULL;
        end else begin
          slot_val[tail_ptr] = val;
          slot_rdy[tail_ptr] = 1'b1;
          r.slot = tail_ptr;
          tail_ptr = wrap_next(tail_ptr);
          held++;
        end
      end
      OP_COMPLETE: begin
        slot_val[pos] = '0;
        // retire done entries from the head; ready flags stay as they are
        while (held != 0 && slot_val[head_ptr] == '0) begin
          head_ptr = wrap_next(head_ptr);
          held--;
        end
      end
      OP_READ_OLDEST: r.data = slot_val[head_ptr];
      default: begin
        if (slot_rdy[pos]) begin
          slot_rdy[pos] = 1'b0;
          r.data = slot_val[pos];
        end else begin
          r.status = ST_NOT_READY;
        end
      end
    endcase
    r.occupied = held;
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      if (n_bad < 50) $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      n_bad++;
    end
  endtask

  always @(posedge clk) begin : watch
    job_reply_t want;
    if (!rst_n) begin
      size_reg = 5'd16;
      for (int i = 0; i < DEPTH; i++) begin
        slot_val[i] = '0;
        slot_rdy[i] = 1'b0;
      end
      head_ptr = '0;
      tail_ptr = '0;
      held = '0;
      reply_q.delete();
      n_bad = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          if (n_bad < 50) $error("result beat with no job outstanding");
          n_bad++;
        end else begin
          want = reply_q.pop_front();
          check_field("status", want.status, out_tuser);
          check_field("data", $signed(want.data), $signed(out_tdata[31:0]));
          check_field("slot_written", want.slot, out_tdata[35:32]);
          check_field("occupied", want.occupied, out_tdata[40:36]);
        end
      end
      if (cfg_wr_en) size_reg = cfg_wr_data;
      if (in_tvalid && in_tready)
        reply_q.push_back(job_window_step(op_t'(in_tuser), in_tdata[31:0], in_tdata[35:32]));
    end
    fail_count    <= n_bad;
    reply_backlog <= reply_q.size();
  end

endmodule

// ===== test/tb_in_order_retire_job_window.sv =====
`timescale 1ns / 1ps
// Top of the job window testbench: clock, reset, stimulus, flow control and verdict.
module tb_in_order_retire_job_window;
  import iorjw_pkg::*;

  localparam int LONG_HOLD       = 300;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int N_PHASES        = 8;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;

  int          fail_count;
  int          reply_backlog;

  // Flow-control knobs, set by the stimulus process; the hold request is raised in phase 0.
  int          tx_idle_pct;
  int          rx_stall_pct;
  bit          hold_request;
  logic [4:0]  live_size;

  in_order_retire_job_window dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  iorjw_window_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .reply_backlog(reply_backlog)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run (every beat stalled on both sides
  // plus a full retire walk), so only a hang trips it.
  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: drive out_tready on the falling edge. A hold request forces a
  // long stretch of backpressure so the pending result waits and stalls the input.
  initial begin : result_sink
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_stall_pct != 0) begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one job beat and hold it until the window takes it. Idle cycles go in
  // front of the beat; valid stays high into the next beat when there is no gap.
  task automatic send_job(input op_t op, input logic [31:0] value, input logic [3:0] pos);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, pos, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Change the window size only once the block has drained every result.
  task automatic program_size(input logic [4:0] sz);
    in_tvalid <= 1'b0;
    while (reply_backlog != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sz;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    live_size = sz;
  endtask

  // Mostly meaningful traffic: adds, completes and takes aimed inside the live
  // window, with zero (already done) values and the signed extremes mixed in.
  task automatic random_job();
    int          r;
    int          span;
    op_t         op;
    logic [31:0] value;
    logic [3:0]  pos;
    span = (live_size == 0) ? 1 : ((live_size > DEPTH) ? DEPTH : live_size);
    r = $urandom_range(99);
    if (r < 35)      op = OP_ADD;
    else if (r < 60) op = OP_COMPLETE;
    else if (r < 70) op = OP_READ_OLDEST;
    else             op = OP_TAKE;
    case ($urandom_range(9))
      0:       value = '0;
      1:       value = 32'h8000_0000;
      2:       value = 32'h7fff_ffff;
      default: value = $urandom;
    endcase
    // occasionally reach past the live window into the rest of the store
    if ($urandom_range(4) != 0) pos = 4'($urandom_range(span - 1));
    else                        pos = 4'($urandom_range(15));
    send_job(op, value, pos);
  endtask

  initial begin : stimulus
    logic [4:0] phase_size [N_PHASES];
    phase_size = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd3, 5'd16};

    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_ADD;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_request = 1'b0;
    live_size    = 5'd16;
    rst_n        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk at the reset size: empty reads, signed extremes, a zero
    // value that retires with its neighbor, double take, and take after retire.
    send_job(OP_READ_OLDEST, 32'h0000_0000, 4'd0);   // empty window reads head
    send_job(OP_TAKE,        32'h0000_0000, 4'd0);   // nothing ready yet
    send_job(OP_COMPLETE,    32'h0000_0000, 4'd0);   // empty, nothing to retire
    send_job(OP_ADD,         32'h7fff_ffff, 4'd15);
    send_job(OP_ADD,         32'h8000_0000, 4'd0);
    send_job(OP_ADD,         32'hffff_ffff, 4'd0);
    send_job(OP_ADD,         32'h0000_0000, 4'd0);   // enters already done
    send_job(OP_ADD,         32'h0000_0001, 4'd0);
    send_job(OP_TAKE,        32'h0000_0000, 4'd1);
    send_job(OP_TAKE,        32'h0000_0000, 4'd1);   // flag already consumed
    send_job(OP_READ_OLDEST, 32'h0000_0000, 4'd0);
    send_job(OP_COMPLETE,    32'h0000_0000, 4'd0);
    send_job(OP_READ_OLDEST, 32'h0000_0000, 4'd0);
    send_job(OP_COMPLETE,    32'h0000_0000, 4'd1);
    send_job(OP_COMPLETE,    32'h0000_0000, 4'd2);   // retires the zero entry too
    send_job(OP_TAKE,        32'h0000_0000, 4'd9);   // outside the held entries
    send_job(OP_TAKE,        32'h0000_0000, 4'd4);
    send_job(OP_COMPLETE,    32'h0000_0000, 4'd4);
    send_job(OP_READ_OLDEST, 32'h0000_0000, 4'd0);
    send_job(OP_COMPLETE,    32'hffff_ffff, 4'd15);  // empty window, top slot
    send_job(OP_TAKE,        32'hffff_ffff, 4'd15);
    send_job(OP_TAKE,        32'h0000_0000, 4'd3);   // retired, flag still set

    // Random phases over eight sizes, among them 0, 17 and 31 that the block clamps, in each flow-control mode.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      program_size(phase_size[ph]);
      case (ph % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 20) hold_request = 1'b1;
        random_job();
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then give the longest retire walk time to show any stray beat.
    while (reply_backlog != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/iorjw_pkg.sv
rtl/iorjw_ram.sv
rtl/in_order_retire_job_window.sv
test/iorjw_window_checker.sv
test/tb_in_order_retire_job_window.sv
